/* hw/rtl/plts_pkg.sv */
// ----------------------------------------------------------------------------
// Token scanner package
// Item types, scanner modes, token kind codes and character codes for the token scanner.
// ----------------------------------------------------------------------------
package plts_pkg;

  localparam int unsigned LenBits   = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         token_kind;
    logic [LenBits-1:0] token_length;
    logic               unterminated;
    logic               nonprint;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ModeIdle    = 4'd0,
    ModeIdent   = 4'd1,
    ModeNumber  = 4'd2,
    ModeSpace   = 4'd3,
    ModeString  = 4'd4,
    ModeStrQ    = 4'd5,
    ModeBrace   = 4'd6,
    ModeSlash   = 4'd7,
    ModeCCom    = 4'd8,
    ModeCStar   = 4'd9,
    ModeLess    = 4'd10,
    ModeGreater = 4'd11,
    ModeColon   = 4'd12
  } mode_e;

  localparam logic [4:0] KindError      = 5'd0;
  localparam logic [4:0] KindEnd        = 5'd1;
  localparam logic [4:0] KindIdent      = 5'd2;
  localparam logic [4:0] KindNumber     = 5'd3;
  localparam logic [4:0] KindString     = 5'd4;
  localparam logic [4:0] KindSpace      = 5'd5;
  localparam logic [4:0] KindBraceCom   = 5'd6;
  localparam logic [4:0] KindSlashCom   = 5'd7;
  localparam logic [4:0] KindPlus       = 5'd8;
  localparam logic [4:0] KindMinus      = 5'd9;
  localparam logic [4:0] KindStar       = 5'd10;
  localparam logic [4:0] KindEqual      = 5'd11;
  localparam logic [4:0] KindNotEqual   = 5'd12;
  localparam logic [4:0] KindLessEq     = 5'd13;
  localparam logic [4:0] KindLess       = 5'd14;
  localparam logic [4:0] KindGreaterEq  = 5'd15;
  localparam logic [4:0] KindGreater    = 5'd16;
  localparam logic [4:0] KindLParen     = 5'd17;
  localparam logic [4:0] KindRParen     = 5'd18;
  localparam logic [4:0] KindLBracket   = 5'd19;
  localparam logic [4:0] KindRBracket   = 5'd20;
  localparam logic [4:0] KindAssign     = 5'd21;
  localparam logic [4:0] KindColon      = 5'd22;
  localparam logic [4:0] KindDot        = 5'd23;
  localparam logic [4:0] KindComma      = 5'd24;
  localparam logic [4:0] KindSemicolon  = 5'd25;

  localparam logic [7:0] ChQuote    = 8'h27;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChLBrace   = 8'h7B;
  localparam logic [7:0] ChRBrace   = 8'h7D;
  localparam logic [7:0] ChStar     = 8'h2A;
  localparam logic [7:0] ChSlash    = 8'h2F;
  localparam logic [7:0] ChLess     = 8'h3C;
  localparam logic [7:0] ChGreater  = 8'h3E;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChEqual    = 8'h3D;
  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [7:0] ChPlus     = 8'h2B;
  localparam logic [7:0] ChMinus    = 8'h2D;
  localparam logic [7:0] ChLParen   = 8'h28;
  localparam logic [7:0] ChRParen   = 8'h29;
  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChSemi     = 8'h3B;

endpackage

/* hw/rtl/pascal_like_token_scanner_unit.sv */
// ----------------------------------------------------------------------------
// Pascal-like token scanner
// Streams text bytes in and emits one item per closed token.
// ----------------------------------------------------------------------------
// The input channel carries one text byte, or an end-of-text mark, per item.
// The output channel carries one token per item: kind, length, flags and a
// last bit that marks the final token caused by one input item.
// An input item is held in an input register and scanned there combinationally;
// the scan writes zero, one or two tokens into a four-entry output queue.
// With an empty queue a token is offered at the output once its input item
// has passed the input register and been written into the output queue.
// The scan proceeds whenever the queue has room for two tokens, so one byte
// per cycle is sustained; an item that yields two tokens needs two output
// transfers, which the queue absorbs when they are not back to back.
// When the receiver stalls, the queue fills and input ready drops.
// Reset puts the scanner between tokens with an empty queue.
// Token lengths saturate at 65535.
module pascal_like_token_scanner_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plts_pkg::out_item_t out_item_o
);

  localparam int unsigned Lb = plts_pkg::LenBits;
  localparam int unsigned Aw = plts_pkg::FifoAw;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_graph(input logic [7:0] c);
    return (c >= 8'h20) && (c <= 8'h7E);
  endfunction

  logic               in_vld_q;
  plts_pkg::in_item_t in_q;
  plts_pkg::mode_e    mode_q, mode_d;
  logic [Lb-1:0]      len_q, len_d;
  logic               ng_q, ng_d;

  plts_pkg::out_item_t       mem_q [plts_pkg::FifoDepth];
  logic [Aw-1:0]             wr_q, rd_q;
  logic [Aw:0]               cnt_q, cnt_d;

  logic                fire;
  logic                pop;
  logic [1:0]          push_n;
  plts_pkg::out_item_t res0, res1;

  logic [7:0]      c;
  logic [Lb-1:0]   grown;
  plts_pkg::mode_e st_mode;
  logic            st_emit;
  logic [4:0]      st_kind;
  logic            fl_valid;
  logic [4:0]      fl_kind;
  logic            fl_unterm;
  logic            fl_ng;
  logic            do_close;
  logic            do_break;
  logic [4:0]      close_kind;
  logic            e0_valid;
  logic            e1_valid;
  plts_pkg::out_item_t e0, e1;

  assign fire       = in_vld_q && (cnt_q <= (Aw+1)'(plts_pkg::FifoDepth - 2));
  assign in_ready_o = !in_vld_q || fire;
  assign pop        = out_valid_o && out_ready_i;

  always_comb begin
    c     = in_q.text_byte;
    grown = (len_q == {Lb{1'b1}}) ? len_q : len_q + Lb'(1);

    st_emit = 1'b0;
    st_kind = plts_pkg::KindError;
    st_mode = plts_pkg::ModeIdle;
    if (is_letter(c)) begin
      st_mode = plts_pkg::ModeIdent;
    end else if (is_digit(c)) begin
      st_mode = plts_pkg::ModeNumber;
    end else if (is_blank(c)) begin
      st_mode = plts_pkg::ModeSpace;
    end else begin
      case (c)
        plts_pkg::ChQuote:    st_mode = plts_pkg::ModeString;
        plts_pkg::ChLBrace:   st_mode = plts_pkg::ModeBrace;
        plts_pkg::ChSlash:    st_mode = plts_pkg::ModeSlash;
        plts_pkg::ChLess:     st_mode = plts_pkg::ModeLess;
        plts_pkg::ChGreater:  st_mode = plts_pkg::ModeGreater;
        plts_pkg::ChColon:    st_mode = plts_pkg::ModeColon;
        plts_pkg::ChPlus:     begin st_emit = 1'b1; st_kind = plts_pkg::KindPlus; end
        plts_pkg::ChMinus:    begin st_emit = 1'b1; st_kind = plts_pkg::KindMinus; end
        plts_pkg::ChStar:     begin st_emit = 1'b1; st_kind = plts_pkg::KindStar; end
        plts_pkg::ChEqual:    begin st_emit = 1'b1; st_kind = plts_pkg::KindEqual; end
        plts_pkg::ChLParen:   begin st_emit = 1'b1; st_kind = plts_pkg::KindLParen; end
        plts_pkg::ChRParen:   begin st_emit = 1'b1; st_kind = plts_pkg::KindRParen; end
        plts_pkg::ChLBracket: begin st_emit = 1'b1; st_kind = plts_pkg::KindLBracket; end
        plts_pkg::ChRBracket: begin st_emit = 1'b1; st_kind = plts_pkg::KindRBracket; end
        plts_pkg::ChDot:      begin st_emit = 1'b1; st_kind = plts_pkg::KindDot; end
        plts_pkg::ChComma:    begin st_emit = 1'b1; st_kind = plts_pkg::KindComma; end
        plts_pkg::ChSemi:     begin st_emit = 1'b1; st_kind = plts_pkg::KindSemicolon; end
        default:              begin st_emit = 1'b1; st_kind = plts_pkg::KindError; end
      endcase
    end

    fl_valid  = 1'b1;
    fl_kind   = plts_pkg::KindError;
    fl_unterm = 1'b0;
    fl_ng     = 1'b0;
    case (mode_q)
      plts_pkg::ModeIdent:   fl_kind = plts_pkg::KindIdent;
      plts_pkg::ModeNumber:  fl_kind = plts_pkg::KindNumber;
      plts_pkg::ModeSpace:   fl_kind = plts_pkg::KindSpace;
      plts_pkg::ModeString:  begin fl_kind = plts_pkg::KindString; fl_unterm = 1'b1; end
      plts_pkg::ModeStrQ:    begin fl_kind = plts_pkg::KindString; fl_ng = ng_q; end
      plts_pkg::ModeBrace:   begin fl_kind = plts_pkg::KindBraceCom; fl_unterm = 1'b1; end
      plts_pkg::ModeSlash:   fl_kind = plts_pkg::KindError;
      plts_pkg::ModeCCom:    begin fl_kind = plts_pkg::KindSlashCom; fl_unterm = 1'b1; end
      plts_pkg::ModeCStar:   begin fl_kind = plts_pkg::KindSlashCom; fl_unterm = 1'b1; end
      plts_pkg::ModeLess:    fl_kind = plts_pkg::KindLess;
      plts_pkg::ModeGreater: fl_kind = plts_pkg::KindGreater;
      plts_pkg::ModeColon:   fl_kind = plts_pkg::KindColon;
      default:               fl_valid = 1'b0;
    endcase

    mode_d     = mode_q;
    len_d      = len_q;
    ng_d       = ng_q;
    do_close   = 1'b0;
    do_break   = 1'b0;
    close_kind = plts_pkg::KindError;
    case (mode_q)
      plts_pkg::ModeIdent: begin
        if (is_letter(c) || is_digit(c)) len_d = grown;
        else do_break = 1'b1;
      end
      plts_pkg::ModeNumber: begin
        if (is_digit(c)) len_d = grown;
        else do_break = 1'b1;
      end
      plts_pkg::ModeSpace: begin
        if (is_blank(c)) len_d = grown;
        else do_break = 1'b1;
      end
      plts_pkg::ModeString: begin
        if (c == plts_pkg::ChQuote) begin
          len_d  = grown;
          mode_d = plts_pkg::ModeStrQ;
        end else if ((c == plts_pkg::ChCr) || (c == plts_pkg::ChLf)) begin
          do_break = 1'b1;
        end else begin
          len_d = grown;
          ng_d  = ng_q | !is_graph(c);
        end
      end
      plts_pkg::ModeStrQ: begin
        if (c == plts_pkg::ChQuote) begin
          len_d  = grown;
          mode_d = plts_pkg::ModeString;
        end else begin
          do_break = 1'b1;
        end
      end
      plts_pkg::ModeBrace: begin
        if (c == plts_pkg::ChRBrace) begin
          do_close   = 1'b1;
          close_kind = plts_pkg::KindBraceCom;
        end else begin
          len_d = grown;
        end
      end
      plts_pkg::ModeSlash: begin
        if (c == plts_pkg::ChStar) begin
          len_d  = grown;
          mode_d = plts_pkg::ModeCCom;
        end else begin
          do_break = 1'b1;
        end
      end
      plts_pkg::ModeCCom: begin
        len_d = grown;
        if (c == plts_pkg::ChStar) mode_d = plts_pkg::ModeCStar;
      end
      plts_pkg::ModeCStar: begin
        if (c == plts_pkg::ChSlash) begin
          do_close   = 1'b1;
          close_kind = plts_pkg::KindSlashCom;
        end else begin
          len_d = grown;
          if (c != plts_pkg::ChStar) mode_d = plts_pkg::ModeCCom;
        end
      end
      plts_pkg::ModeLess: begin
        if (c == plts_pkg::ChGreater) begin
          do_close   = 1'b1;
          close_kind = plts_pkg::KindNotEqual;
        end else if (c == plts_pkg::ChEqual) begin
          do_close   = 1'b1;
          close_kind = plts_pkg::KindLessEq;
        end else begin
          do_break = 1'b1;
        end
      end
      plts_pkg::ModeGreater: begin
        if (c == plts_pkg::ChEqual) begin
          do_close   = 1'b1;
          close_kind = plts_pkg::KindGreaterEq;
        end else begin
          do_break = 1'b1;
        end
      end
      plts_pkg::ModeColon: begin
        if (c == plts_pkg::ChEqual) begin
          do_close   = 1'b1;
          close_kind = plts_pkg::KindAssign;
        end else begin
          do_break = 1'b1;
        end
      end
      default: do_break = 1'b1;
    endcase

    e0              = '0;
    e0.token_kind   = fl_kind;
    e0.token_length = len_q;
    e0.unterminated = fl_unterm;
    e0.nonprint     = fl_ng;
    e1              = '0;
    e0_valid        = 1'b0;
    e1_valid        = 1'b0;

    if (in_q.end_of_text) begin
      e0_valid      = fl_valid;
      e1_valid      = 1'b1;
      e1.token_kind = plts_pkg::KindEnd;
      mode_d        = plts_pkg::ModeIdle;
      len_d         = '0;
      ng_d          = 1'b0;
    end else if (do_close) begin
      e1_valid        = 1'b1;
      e1.token_kind   = close_kind;
      e1.token_length = grown;
      mode_d          = plts_pkg::ModeIdle;
      len_d           = '0;
      ng_d            = 1'b0;
    end else if (do_break) begin
      e0_valid        = fl_valid;
      e1_valid        = st_emit;
      e1.token_kind   = st_kind;
      e1.token_length = Lb'(1);
      mode_d          = st_emit ? plts_pkg::ModeIdle : st_mode;
      len_d           = st_emit ? '0 : Lb'(1);
      ng_d            = 1'b0;
    end

    e1.last = 1'b1;
    e0.last = !e1_valid;
    res0    = e0_valid ? e0 : e1;
    res1    = e1;
    push_n  = fire ? ({1'b0, e0_valid} + {1'b0, e1_valid}) : 2'd0;
    cnt_d   = cnt_q + (Aw+1)'(push_n) - (Aw+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= plts_pkg::ModeIdle;
      len_q    <= '0;
      ng_q     <= 1'b0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        ng_q   <= ng_d;
      end
      wr_q  <= wr_q + Aw'(push_n);
      if (pop) begin
        rd_q <= rd_q + Aw'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + Aw'(1)] <= res1;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];

endmodule

/* hw/rtl/plts_checker.sv */
// ----------------------------------------------------------------------------
// Token scanner checker
// Port-level assertions for the token scanner, bound to the scanner module.
// ----------------------------------------------------------------------------
module plts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input plts_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input plts_pkg::out_item_t out_item_o
);

  logic in_seen;

  assign in_seen = in_valid_i && in_ready_o && (in_item_i.end_of_text || !in_item_i.end_of_text);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before the item was taken");

  a_out_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_seen |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  a_end_token_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.token_kind == plts_pkg::KindEnd) |->
      (out_item_o.token_length == '0) && !out_item_o.unterminated &&
      !out_item_o.nonprint && out_item_o.last)
    else $error("end token carries length, flags or lacks last");

  a_nonprint_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.nonprint |->
      (out_item_o.token_kind == plts_pkg::KindString) && !out_item_o.unterminated)
    else $error("non-printable flag on a token that is not a closed string");

endmodule

bind pascal_like_token_scanner_unit plts_checker u_plts_checker (.*);
